// File: rtl/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POLL_MS          = 3'd5;

	localparam logic [7:0]  RST_LATCH_TICKS      = 8'd12;
	localparam logic [7:0]  RST_SETTLE_TICKS     = 8'd6;
	localparam logic [7:0]  RST_CLOCK_HIGH_TICKS = 8'd6;
	localparam logic [7:0]  RST_CLOCK_LOW_TICKS  = 8'd6;
	localparam logic [15:0] RST_TICKS_PER_MS     = 16'd1000;
	localparam logic [9:0]  RST_POLL_MS          = 10'd2;

	typedef struct packed {
		logic [7:0]  latch_ticks;
		logic [7:0]  settle_ticks;
		logic [7:0]  clock_high_ticks;
		logic [7:0]  clock_low_ticks;
		logic [15:0] ticks_per_ms;
		logic [9:0]  poll_ms;
	} cfg_t;

endpackage

// File: rtl/nps_ifs.sv
`timescale 1ns / 1ps

interface nps_in_if;
	logic valid;
	logic ready;
	logic data_pin;

	modport source (output valid, output data_pin, input ready);
	modport sink (input valid, input data_pin, output ready);
endinterface

interface nps_out_if #(
	parameter int BUTTON_COUNT = 11
);
	logic                    valid;
	logic                    ready;
	logic                    latch_level;
	logic                    clock_level;
	logic [BUTTON_COUNT-1:0] buttons;
	logic                    frame_done;

	modport source (output valid, output latch_level, output clock_level, output buttons,
		output frame_done, input ready);
	modport sink (input valid, input latch_level, input clock_level, input buttons,
		input frame_done, output ready);
endinterface

interface nps_cfg_if
	import nps_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/nps_cfg_regs.sv
`timescale 1ns / 1ps

module nps_cfg_regs
	import nps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	nps_cfg_if.sink    cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.latch_ticks      <= RST_LATCH_TICKS;
			regs_q.settle_ticks     <= RST_SETTLE_TICKS;
			regs_q.clock_high_ticks <= RST_CLOCK_HIGH_TICKS;
			regs_q.clock_low_ticks  <= RST_CLOCK_LOW_TICKS;
			regs_q.ticks_per_ms     <= RST_TICKS_PER_MS;
			regs_q.poll_ms          <= RST_POLL_MS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LATCH_TICKS:      regs_q.latch_ticks      <= cfg.data[7:0];
				REG_SETTLE_TICKS:     regs_q.settle_ticks     <= cfg.data[7:0];
				REG_CLOCK_HIGH_TICKS: regs_q.clock_high_ticks <= cfg.data[7:0];
				REG_CLOCK_LOW_TICKS:  regs_q.clock_low_ticks  <= cfg.data[7:0];
				REG_TICKS_PER_MS:     regs_q.ticks_per_ms     <= cfg.data[15:0];
				REG_POLL_MS:          regs_q.poll_ms          <= cfg.data[9:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/nps_seq.sv
`timescale 1ns / 1ps

module nps_seq
	import nps_pkg::*;
#(
	parameter int BUTTON_COUNT = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       regs,
	nps_in_if.sink     pad,
	nps_out_if.source  res
);

	localparam int BIT_W = $clog2(BUTTON_COUNT);

	typedef enum logic [2:0] {
		PH_LATCH,
		PH_SETTLE,
		PH_CLK_HIGH,
		PH_CLK_LOW,
		PH_GAP
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic [15:0]             tick_q, tick_d;
	logic [9:0]              ms_q, ms_d;
	logic [BIT_W-1:0]        bit_q, bit_d;
	logic [BUTTON_COUNT-1:0] shift_q, shift_d;
	logic [BUTTON_COUNT-1:0] held_q, held_d;

	logic                    out_valid_q;
	logic                    latch_q, clock_q, done_q;
	logic [BUTTON_COUNT-1:0] buttons_q;

	logic [15:0] limit_raw, limit;
	logic [9:0]  poll_lim;
	logic        tick_end, ms_end, last_bit, done_d, accept;

	assign pad.ready = !out_valid_q || res.ready;
	assign accept    = pad.valid && pad.ready;

	assign res.valid       = out_valid_q;
	assign res.latch_level = latch_q;
	assign res.clock_level = clock_q;
	assign res.buttons     = buttons_q;
	assign res.frame_done  = done_q;

	always_comb begin
		case (phase_q)
			PH_SETTLE:   limit_raw = {8'd0, regs.settle_ticks};
			PH_CLK_HIGH: limit_raw = {8'd0, regs.clock_high_ticks};
			PH_CLK_LOW:  limit_raw = {8'd0, regs.clock_low_ticks};
			PH_GAP:      limit_raw = regs.ticks_per_ms;
			default:     limit_raw = {8'd0, regs.latch_ticks};
		endcase
		limit    = (limit_raw == 16'd0) ? 16'd1 : limit_raw;
		poll_lim = (regs.poll_ms == 10'd0) ? 10'd1 : regs.poll_ms;
		tick_end = ({1'b0, tick_q} + 17'd1) >= {1'b0, limit};
		ms_end   = ({1'b0, ms_q} + 11'd1) >= {1'b0, poll_lim};
		last_bit = bit_q == BIT_W'(BUTTON_COUNT - 1);
	end

	always_comb begin
		shift_d = shift_q;
		held_d  = held_q;
		done_d  = 1'b0;
		phase_d = phase_q;
		tick_d  = tick_q + 16'd1;
		ms_d    = ms_q;
		bit_d   = bit_q;

		if (phase_q == PH_CLK_HIGH && tick_q == 16'd0 && !pad.data_pin) begin
			shift_d[bit_q] = 1'b1;
		end
		if (phase_q == PH_GAP && tick_q == 16'd0 && ms_q == 10'd0) begin
			held_d = shift_q;
			done_d = 1'b1;
		end

		if (tick_end) begin
			tick_d = 16'd0;
			case (phase_q)
				PH_SETTLE: begin
					bit_d   = '0;
					shift_d = '0;
					phase_d = PH_CLK_HIGH;
				end
				PH_CLK_HIGH: phase_d = PH_CLK_LOW;
				PH_CLK_LOW: begin
					if (last_bit) begin
						ms_d    = 10'd0;
						phase_d = PH_GAP;
					end else begin
						bit_d   = bit_q + BIT_W'(1);
						phase_d = PH_CLK_HIGH;
					end
				end
				PH_GAP: begin
					if (ms_end) begin
						ms_d    = 10'd0;
						phase_d = PH_LATCH;
					end else begin
						ms_d = ms_q + 10'd1;
					end
				end
				default: phase_d = PH_SETTLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LATCH;
			tick_q      <= 16'd0;
			ms_q        <= 10'd0;
			bit_q       <= '0;
			shift_q     <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
			latch_q     <= 1'b0;
			clock_q     <= 1'b0;
			buttons_q   <= '0;
			done_q      <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			ms_q        <= ms_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			held_q      <= held_d;
			out_valid_q <= 1'b1;
			latch_q     <= phase_q == PH_LATCH;
			clock_q     <= phase_q == PH_CLK_HIGH;
			buttons_q   <= held_d;
			done_q      <= done_d;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/nes_pad_serial_reader.sv
`timescale 1ns / 1ps

// Console side of an extended NES pad link. Every transaction on pad is one timing tick carrying
// the sampled data pin; it yields exactly one transaction on res with the latch and clock levels
// for that tick, the last published button word and the frame-done flag. One tick is taken per
// clock cycle unless res stalls, with the result registered: the phase timers and shift register
// update in a single pass and the result register is refilled in the same cycle it is drained.
// Configuration writes on cfg are always accepted; indexes past the last register are ignored.

module nes_pad_serial_reader
	import nps_pkg::*;
#(
	parameter int BUTTON_COUNT = 11
) (
	input  logic       clk,
	input  logic       arst_n,
	nps_in_if.sink     pad,
	nps_out_if.source  res,
	nps_cfg_if.sink    cfg
);

	cfg_t regs;

	nps_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	nps_seq #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.pad    (pad),
		.res    (res)
	);

endmodule

// File: rtl/nps_checker.sv
`timescale 1ns / 1ps

module nps_checker #(
	parameter int BUTTON_COUNT = 11
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    pad_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic                    latch_level,
	input logic                    clock_level,
	input logic [BUTTON_COUNT-1:0] buttons,
	input logic                    frame_done
);

	logic [BUTTON_COUNT-1:0] last_buttons_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buttons_q <= '0;
		end else if (res_valid && res_ready) begin
			last_buttons_q <= buttons;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(buttons) && $stable(frame_done)
			&& $stable(latch_level) && $stable(clock_level))
		else $error("stalled transaction changed");

	a_lines_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(latch_level && clock_level))
		else $error("latch and clock high together");

	a_done_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_done |-> !latch_level && !clock_level)
		else $error("frame_done outside gap");

	a_word_steady: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !frame_done |-> buttons == last_buttons_q)
		else $error("button word changed without frame_done");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pad_ready)
		else $error("tick refused with empty result register");

endmodule

bind nes_pad_serial_reader nps_checker #(
	.BUTTON_COUNT (BUTTON_COUNT)
) u_nps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pad_ready   (pad.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.latch_level (res.latch_level),
	.clock_level (res.clock_level),
	.buttons     (res.buttons),
	.frame_done  (res.frame_done)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import nps_pkg::*;

	localparam int BUTTONS     = 11;
	localparam int DIR_N       = 28;
	localparam int DIR_SPLIT   = 2;
	localparam int ITEM_TARGET = 1700;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int REPORT_MAX  = 10;
	localparam int HOLD_PHASE  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic [2:0] {
		PH_LATCH,
		PH_SETTLE,
		PH_CLK_HIGH,
		PH_CLK_LOW,
		PH_GAP
	} read_phase_e;

	typedef enum int {
		PINS_RANDOM,
		PINS_PRESSED,
		PINS_RELEASED
	} pin_mix_e;

	typedef struct packed {
		logic               latch_level;
		logic               clock_level;
		logic [BUTTONS-1:0] buttons;
		logic               frame_done;
	} pad_res_t;

	typedef struct packed {
		logic     pin;
		logic     typed;
		pad_res_t want;
	} tick_row_t;

	localparam pad_res_t NO_WANT     = '0;
	localparam pad_res_t LATCH_CLEAR = {1'b1, 1'b0, 11'h000, 1'b0};
	localparam pad_res_t PUBLISH_ALL = {1'b0, 1'b0, 11'h7ff, 1'b1};
	localparam pad_res_t LATCH_HELD  = {1'b1, 1'b0, 11'h7ff, 1'b0};

	// two latch ticks at reset timing, then every register at zero: one full frame
	// with every button pressed, the publish tick and the next latch
	localparam tick_row_t DIR_TAB [DIR_N] = '{
		{1'b1, 1'b1, LATCH_CLEAR}, {1'b0, 1'b1, LATCH_CLEAR},
		{1'b1, 1'b1, LATCH_CLEAR}, {1'b0, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b0, 1'b0, NO_WANT}, {1'b1, 1'b0, NO_WANT},
		{1'b1, 1'b1, PUBLISH_ALL}, {1'b0, 1'b1, LATCH_HELD}
	};

	logic clk;
	logic arst_n;

	nps_in_if pad();
	nps_out_if #(.BUTTON_COUNT(BUTTONS)) res();
	nps_cfg_if cfg();

	nes_pad_serial_reader #(.BUTTON_COUNT(BUTTONS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pad(pad),
		.res(res),
		.cfg(cfg)
	);

	read_phase_e        rd_phase;
	logic [15:0]        rd_ticks;
	logic [9:0]         rd_ms;
	logic [3:0]         rd_bit;
	logic [BUTTONS-1:0] rd_shift;
	logic [BUTTONS-1:0] rd_held;
	cfg_t               rd_cfg;
	pad_res_t           want_q [$];

	int unsigned ticks_sent;
	int unsigned settings;
	int unsigned checked;
	int unsigned frames_seen;
	int unsigned mism;
	logic        calm;
	logic        hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [16:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 17'd1 : {1'b0, v};
	endfunction

	function automatic pad_res_t step_reader(input logic pin);
		pad_res_t    r;
		logic [16:0] lim;
		case (rd_phase)
			PH_SETTLE:   lim = at_least_one({8'd0, rd_cfg.settle_ticks});
			PH_CLK_HIGH: lim = at_least_one({8'd0, rd_cfg.clock_high_ticks});
			PH_CLK_LOW:  lim = at_least_one({8'd0, rd_cfg.clock_low_ticks});
			PH_GAP:      lim = at_least_one(rd_cfg.ticks_per_ms);
			default:     lim = at_least_one({8'd0, rd_cfg.latch_ticks});
		endcase
		r = '0;
		if (rd_phase == PH_CLK_HIGH && rd_ticks == 16'd0 && !pin)
			rd_shift[rd_bit] = 1'b1;
		if (rd_phase == PH_GAP && rd_ticks == 16'd0 && rd_ms == 10'd0) begin
			rd_held = rd_shift;
			r.frame_done = 1'b1;
		end
		r.latch_level = (rd_phase == PH_LATCH);
		r.clock_level = (rd_phase == PH_CLK_HIGH);
		r.buttons = rd_held;
		if ({1'b0, rd_ticks} + 17'd1 < lim) begin
			rd_ticks = rd_ticks + 16'd1;
		end else begin
			rd_ticks = 16'd0;
			case (rd_phase)
				PH_SETTLE: begin
					rd_bit = 4'd0;
					rd_shift = '0;
					rd_phase = PH_CLK_HIGH;
				end
				PH_CLK_HIGH: rd_phase = PH_CLK_LOW;
				PH_CLK_LOW: begin
					if (rd_bit + 1 >= BUTTONS) begin
						rd_ms = 10'd0;
						rd_phase = PH_GAP;
					end else begin
						rd_bit = rd_bit + 4'd1;
						rd_phase = PH_CLK_HIGH;
					end
				end
				PH_GAP: begin
					if ({1'b0, rd_ms} + 11'd1 >= at_least_one({6'd0, rd_cfg.poll_ms})) begin
						rd_ms = 10'd0;
						rd_phase = PH_LATCH;
					end else begin
						rd_ms = rd_ms + 10'd1;
					end
				end
				default: rd_phase = PH_SETTLE;
			endcase
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] corner(input logic [15:0] top);
		case ($urandom_range(0, 2))
			0:       return 16'd0;
			1:       return 16'd1;
			default: return top;
		endcase
	endfunction

	task automatic put_tick(input logic pin, input logic typed, input pad_res_t want);
		pad_res_t guess;
		pad.valid <= 1'b1;
		pad.data_pin <= pin;
		do @(posedge clk); while (!pad.ready);
		guess = step_reader(pin);
		want_q.push_back(typed ? want : guess);
		ticks_sent++;
	endtask

	task automatic pause_pad();
		int unsigned g;
		g = pick_gap();
		if (g != 0) begin
			pad.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_results(input int unsigned tail);
		pad.valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c, input logic noise);
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		for (int k = REG_LATCH_TICKS; k <= REG_SPARE; k++) begin
			idx = CFG_IDX_W'(k);
			val = CFG_DATA_W'($urandom);
			case (idx)
				REG_LATCH_TICKS:      val = {noise ? val[15:8] : 8'h00, c.latch_ticks};
				REG_SETTLE_TICKS:     val = {noise ? val[15:8] : 8'h00, c.settle_ticks};
				REG_CLOCK_HIGH_TICKS: val = {noise ? val[15:8] : 8'h00, c.clock_high_ticks};
				REG_CLOCK_LOW_TICKS:  val = {noise ? val[15:8] : 8'h00, c.clock_low_ticks};
				REG_TICKS_PER_MS:     val = c.ticks_per_ms;
				REG_POLL_MS:          val = {noise ? val[15:10] : 6'h00, c.poll_ms};
				default: ;
			endcase
			cfg.valid <= 1'b1;
			cfg.index <= idx;
			cfg.data <= val;
			do @(posedge clk); while (!cfg.ready);
			case (idx)
				REG_LATCH_TICKS:      rd_cfg.latch_ticks = val[7:0];
				REG_SETTLE_TICKS:     rd_cfg.settle_ticks = val[7:0];
				REG_CLOCK_HIGH_TICKS: rd_cfg.clock_high_ticks = val[7:0];
				REG_CLOCK_LOW_TICKS:  rd_cfg.clock_low_ticks = val[7:0];
				REG_TICKS_PER_MS:     rd_cfg.ticks_per_ms = val;
				REG_POLL_MS:          rd_cfg.poll_ms = val[9:0];
				default: ;
			endcase
		end
		cfg.valid <= 1'b0;
		settings++;
	endtask

	initial begin
		cfg_t        c;
		logic        noise;
		logic        pin;
		pin_mix_e    mix;
		int unsigned n_items;
		int unsigned roll;
		int unsigned phase_no;

		arst_n <= 1'b0;
		pad.valid <= 1'b0;
		pad.data_pin <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_LATCH_TICKS;
		cfg.data <= '0;
		calm = 1'b0;
		hold_req = 1'b0;
		ticks_sent = 0;
		settings = 0;
		rd_cfg = {RST_LATCH_TICKS, RST_SETTLE_TICKS, RST_CLOCK_HIGH_TICKS,
			RST_CLOCK_LOW_TICKS, RST_TICKS_PER_MS, RST_POLL_MS};
		rd_phase = PH_LATCH;
		rd_ticks = '0;
		rd_ms = '0;
		rd_bit = '0;
		rd_shift = '0;
		rd_held = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			if (i == DIR_SPLIT) begin
				drain_results(2);
				write_regs('0, 1'b0);
			end
			put_tick(DIR_TAB[i].pin, DIR_TAB[i].typed, DIR_TAB[i].want);
			pause_pad();
		end

		phase_no = 0;
		while (ticks_sent < ITEM_TARGET) begin
			drain_results(2);
			roll = $urandom_range(0, 9);
			if (phase_no == 0 || roll == 0) begin
				c = {8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 10'h3ff};
			end else if (phase_no == 1 || roll == 1) begin
				c.latch_ticks = 8'(corner(16'hff));
				c.settle_ticks = 8'(corner(16'hff));
				c.clock_high_ticks = 8'(corner(16'hff));
				c.clock_low_ticks = 8'(corner(16'hff));
				c.ticks_per_ms = corner(16'hffff);
				c.poll_ms = 10'(corner(16'h3ff));
			end else begin
				c.latch_ticks = 8'($urandom_range(0, 4));
				c.settle_ticks = 8'($urandom_range(0, 4));
				c.clock_high_ticks = 8'($urandom_range(0, 3));
				c.clock_low_ticks = 8'($urandom_range(0, 3));
				c.ticks_per_ms = 16'($urandom_range(0, 6));
				c.poll_ms = 10'($urandom_range(0, 3));
			end
			noise = ($urandom_range(0, 3) == 0);
			write_regs(c, noise);

			mix = pin_mix_e'($urandom_range(0, 2));
			calm = ($urandom_range(0, 4) == 0) || phase_no == HOLD_PHASE;
			n_items = $urandom_range(40, 160);
			if (phase_no == HOLD_PHASE) begin
				n_items = 400;
				hold_req = 1'b1;
			end
			repeat (n_items) begin
				case (mix)
					PINS_PRESSED:  pin = ($urandom_range(0, 7) == 0);
					PINS_RELEASED: pin = ($urandom_range(0, 7) != 0);
					default:       pin = 1'($urandom_range(0, 1));
				endcase
				put_tick(pin, 1'b0, NO_WANT);
				pause_pad();
			end
			phase_no++;
		end

		drain_results(8);
		$display("Ran %0d pad ticks over %0d register settings, %0d results checked",
			ticks_sent, settings, checked);
		$display("%0d button words were published", frames_seen);
		if (mism == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		pad_res_t    got;
		pad_res_t    w;
		int unsigned stall_left;

		res.ready <= 1'b0;
		stall_left = 0;
		checked = 0;
		frames_seen = 0;
		mism = 0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				got = {res.latch_level, res.clock_level, res.buttons, res.frame_done};
				if (want_q.size() == 0) begin
					mism++;
					if (mism <= REPORT_MAX)
						$display("result %0d arrived with nothing outstanding", checked);
				end else begin
					w = want_q.pop_front();
					if (got.latch_level !== w.latch_level || got.clock_level !== w.clock_level
							|| got.buttons !== w.buttons || got.frame_done !== w.frame_done) begin
						mism++;
						if (mism <= REPORT_MAX)
							$display("result %0d: latch %b/%b clock %b/%b buttons %h/%h done %b/%b (exp/act)",
								checked, w.latch_level, got.latch_level, w.clock_level,
								got.clock_level, w.buttons, got.buttons, w.frame_done,
								got.frame_done);
					end
				end
				if (got.frame_done === 1'b1)
					frames_seen++;
				checked++;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		int unsigned idle;

		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pad.valid && pad.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				idle = 0;
			else
				idle++;
		end
		$display("no transaction for %0d cycles, %0d results outstanding", idle, want_q.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
